/* hdl/fpnc_pkg.sv */
// Shared types and constants for the Fitch parsimony node-cost engine.
package fpnc_pkg;

	localparam int DEF_MAX_NODES = 32;
	localparam int DEF_MAX_SITES = 256;

	localparam int NODE_FW  = 5;
	localparam int SITE_FW  = 8;
	localparam int SET_W    = 4;
	localparam int COST_W   = 16;
	localparam int NSITES_W = 9;

	localparam logic [COST_W-1:0] COST_MAX = '1;

	// request opcodes carried in the mode field
	localparam logic MODE_LOAD    = 1'b0;
	localparam logic MODE_COMBINE = 1'b1;

	// command queue between front and back
	localparam int QDEPTH = 2;

	typedef struct packed {
		logic               mode;
		logic [NODE_FW-1:0] node;
		logic [NODE_FW-1:0] left_child;
		logic [NODE_FW-1:0] right_child;
		logic [SITE_FW-1:0] site;
		logic [SET_W-1:0]   site_set;
	} fpnc_req_t;

	typedef struct packed {
		logic [NODE_FW-1:0] result_node;
		logic [COST_W-1:0]  node_cost;
	} fpnc_res_t;

	typedef struct packed {
		logic      valid;
		fpnc_req_t cmd;
	} fpnc_q2b_t;

endpackage

/* hdl/fitch_parsimony_node_cost.sv */
// Top level of the Fitch parsimony node-cost engine.
// A request is taken on a clock edge with start high and busy low; busy only rises
// when the two-entry command queue is full. A load request (mode 0) writes one leaf
// set and zeroes that leaf's cost and gives no result. A combine request (mode 1)
// is dequeued, then walks num_sites sites, num_sites clamped to MAX_SITES, through
// the set store (both children read in the same cycle, the merged set written in the
// following one), then reads the cost store and adds and saturates. The back end
// takes no new request until the current combine has finished. Each combine result
// shows on result for exactly one cycle with result_valid high, in the cycle after
// the sum, and cannot be stalled. Requests naming a node at or above MAX_NODES, or
// a load site at or above MAX_SITES, are dropped without a result. num_sites resets
// to 1, is written through cfg_valid/cfg_data (cfg_ready is always high) and must
// only be changed while no request is in flight. Neither store is initialized:
// combining a node whose sets or cost were never written returns an unspecified
// cost.
module fitch_parsimony_node_cost
	import fpnc_pkg::*;
#(
	parameter int MAX_NODES = DEF_MAX_NODES,
	parameter int MAX_SITES = DEF_MAX_SITES
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  fpnc_req_t           request,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [NSITES_W-1:0] cfg_data,
	output logic                result_valid,
	output fpnc_res_t           result
);

	logic [NSITES_W-1:0] num_sites_q;
	fpnc_q2b_t           q2b;
	logic                pop;

	// single configuration register, always writable
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_sites_q <= NSITES_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			num_sites_q <= cfg_data;
		end
	end

	// front: range filter plus queue
	fpnc_front #(
		.MAX_NODES (MAX_NODES),
		.MAX_SITES (MAX_SITES)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.request (request),
		.q2b     (q2b),
		.pop     (pop)
	);

	// back: stores and the site walk
	fpnc_back #(
		.MAX_NODES (MAX_NODES),
		.MAX_SITES (MAX_SITES)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q2b          (q2b),
		.pop          (pop),
		.num_sites    (num_sites_q),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

/* hdl/fpnc_front.sv */
// Request intake: range filter and a short command queue toward the back end.
module fpnc_front
	import fpnc_pkg::*;
#(
	parameter int MAX_NODES = DEF_MAX_NODES,
	parameter int MAX_SITES = DEF_MAX_SITES
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  fpnc_req_t request,
	output fpnc_q2b_t q2b,
	input  logic      pop
);

	localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CNT_W = $clog2(QDEPTH + 1);

	fpnc_req_t        q_mem [QDEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             accept, item_ok, push, pop_ok;

	assign busy   = (cnt_q == CNT_W'(QDEPTH));
	assign accept = start && !busy;

	// out-of-range requests are dropped here
	always_comb begin
		item_ok = int'(request.node) < MAX_NODES;
		if (request.mode == MODE_LOAD) begin
			item_ok = item_ok && (int'(request.site) < MAX_SITES);
		end else begin
			item_ok = item_ok && (int'(request.left_child) < MAX_NODES)
				&& (int'(request.right_child) < MAX_NODES);
		end
	end

	assign push   = accept && item_ok;
	assign pop_ok = pop && (cnt_q != '0);

	assign q2b.valid = (cnt_q != '0);
	assign q2b.cmd   = q_mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_ptr_q] <= request;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop_ok) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop_ok) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!push && pop_ok) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

/* hdl/fpnc_back.sv */
// Execution back end: set store, cost store and the per-site Fitch walk.
module fpnc_back
	import fpnc_pkg::*;
#(
	parameter int MAX_NODES = DEF_MAX_NODES,
	parameter int MAX_SITES = DEF_MAX_SITES
) (
	input  logic                clk,
	input  logic                arst_n,
	input  fpnc_q2b_t           q2b,
	output logic                pop,
	input  logic [NSITES_W-1:0] num_sites,
	output logic                result_valid,
	output fpnc_res_t           result
);

	localparam int NODE_W = $clog2(MAX_NODES);
	localparam int SITE_W = (MAX_SITES > 1) ? $clog2(MAX_SITES) : 1;
	localparam int DEPTH  = MAX_NODES * MAX_SITES;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(MAX_SITES + 1);
	localparam int CMP_W  = ((CNT_W > NSITES_W) ? CNT_W : NSITES_W) + 1;
	localparam int SUM_W  = ((CNT_W > COST_W) ? CNT_W : COST_W) + 2;

	typedef enum logic [3:0] {
		B_IDLE     = 4'b0001,
		B_WALK     = 4'b0010,
		B_COST_RD  = 4'b0100,
		B_COST_SUM = 4'b1000
	} bstate_t;

	function automatic logic [ADDR_W-1:0] node_base(input logic [NODE_W-1:0] n);
		return ADDR_W'(int'(n) * MAX_SITES);
	endfunction

	bstate_t            state_q;
	logic [NODE_W-1:0]  dst_q, lc_q, rc_q;
	logic [ADDR_W-1:0]  dst_base_q, lc_base_q, rc_base_q;
	logic [CNT_W-1:0]   n_q, rd_cnt_q, changes_q;
	logic               rd_vld_s1;
	logic [SITE_W-1:0]  site_s1;
	logic [SET_W-1:0]   lset_s1, rset_s1;
	logic [COST_W-1:0]  lcost_q, rcost_q;

	logic [SET_W-1:0]   set_mem  [DEPTH];
	logic [COST_W-1:0]  cost_mem [MAX_NODES];

	logic               set_we, cost_we;
	logic [ADDR_W-1:0]  set_waddr, l_raddr, r_raddr;
	logic [SET_W-1:0]   set_wdata, both, merged;
	logic [NODE_W-1:0]  cost_waddr, cmd_node, cmd_lc, cmd_rc;
	logic [COST_W-1:0]  cost_wdata;
	logic [CNT_W-1:0]   n_clamped;
	logic [SUM_W-1:0]   total;
	logic [COST_W-1:0]  total_sat;
	logic               is_load, is_combine, no_common;

	assign pop        = (state_q == B_IDLE) && q2b.valid;
	assign is_load    = pop && (q2b.cmd.mode == MODE_LOAD);
	assign is_combine = pop && (q2b.cmd.mode == MODE_COMBINE);
	assign cmd_node   = NODE_W'(q2b.cmd.node);
	assign cmd_lc     = NODE_W'(q2b.cmd.left_child);
	assign cmd_rc     = NODE_W'(q2b.cmd.right_child);

	assign n_clamped = (CMP_W'(num_sites) > CMP_W'(MAX_SITES))
		? CNT_W'(MAX_SITES) : CNT_W'(num_sites);

	// one site per cycle: read both children now, write destination next cycle
	assign l_raddr = lc_base_q + ADDR_W'(rd_cnt_q[SITE_W-1:0]);
	assign r_raddr = rc_base_q + ADDR_W'(rd_cnt_q[SITE_W-1:0]);

	assign both      = lset_s1 & rset_s1;
	assign no_common = (both == '0);
	assign merged    = no_common ? (lset_s1 | rset_s1) : both;

	always_comb begin
		set_we    = 1'b0;
		set_waddr = dst_base_q + ADDR_W'(site_s1);
		set_wdata = merged;
		if (is_load) begin
			set_we    = 1'b1;
			set_waddr = node_base(cmd_node) + ADDR_W'(q2b.cmd.site);
			set_wdata = q2b.cmd.site_set;
		end else if (rd_vld_s1) begin
			set_we = 1'b1;
		end
	end

	assign total     = SUM_W'(lcost_q) + SUM_W'(rcost_q) + SUM_W'(changes_q);
	assign total_sat = (total > SUM_W'(COST_MAX)) ? COST_MAX : total[COST_W-1:0];

	always_comb begin
		cost_we    = 1'b0;
		cost_waddr = dst_q;
		cost_wdata = total_sat;
		if (is_load) begin
			cost_we    = 1'b1;
			cost_waddr = cmd_node;
			cost_wdata = '0;
		end else if (state_q == B_COST_SUM) begin
			cost_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (set_we) begin
			set_mem[set_waddr] <= set_wdata;
		end
		lset_s1 <= set_mem[l_raddr];
		rset_s1 <= set_mem[r_raddr];
	end

	always_ff @(posedge clk) begin
		if (cost_we) begin
			cost_mem[cost_waddr] <= cost_wdata;
		end
		lcost_q <= cost_mem[lc_q];
		rcost_q <= cost_mem[rc_q];
	end

	always_ff @(posedge clk) begin
		if (is_combine) begin
			dst_q      <= cmd_node;
			lc_q       <= cmd_lc;
			rc_q       <= cmd_rc;
			dst_base_q <= node_base(cmd_node);
			lc_base_q  <= node_base(cmd_lc);
			rc_base_q  <= node_base(cmd_rc);
			n_q        <= n_clamped;
		end
		site_s1 <= rd_cnt_q[SITE_W-1:0];
		if (state_q == B_COST_SUM) begin
			result.result_node <= NODE_FW'(dst_q);
			result.node_cost   <= total_sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= B_IDLE;
			rd_cnt_q     <= '0;
			changes_q    <= '0;
			rd_vld_s1    <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			rd_vld_s1    <= (state_q == B_WALK);
			result_valid <= (state_q == B_COST_SUM);
			if (rd_vld_s1 && no_common) begin
				changes_q <= changes_q + 1'b1;
			end
			unique case (state_q)
				B_IDLE: begin
					if (is_combine) begin
						rd_cnt_q  <= '0;
						changes_q <= '0;
						state_q   <= (n_clamped == '0) ? B_COST_RD : B_WALK;
					end
				end
				B_WALK: begin
					rd_cnt_q <= rd_cnt_q + 1'b1;
					if (rd_cnt_q == n_q - 1'b1) begin
						state_q <= B_COST_RD;
					end
				end
				B_COST_RD: begin
					state_q <= B_COST_SUM;
				end
				B_COST_SUM: begin
					state_q <= B_IDLE;
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

endmodule

/* hdl/fpnc_checker.sv */
// Port-level checks for the node-cost engine, bound to the top level.
module fpnc_checker
	import fpnc_pkg::*;
#(
	parameter int MAX_NODES = DEF_MAX_NODES
) (
	input logic      clk,
	input logic      arst_n,
	input logic      start,
	input logic      busy,
	input logic      result_valid,
	input fpnc_res_t result
);

	// a combine passes through the dequeue and cost states, so strobes never touch
	a_strobe_gap: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("back-to-back result strobes");

	// the queue only fills through an accepted request
	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start && !busy))
		else $error("busy rose without an accepted request");

	// dropped destinations never produce a result
	a_node_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (int'(result.result_node) < MAX_NODES))
		else $error("result for out-of-range node");

endmodule

bind fitch_parsimony_node_cost fpnc_checker #(
	.MAX_NODES (MAX_NODES)
) u_fpnc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.result_valid (result_valid),
	.result       (result)
);

/* verif/tb_fitch_parsimony_node_cost.sv */
// Self-checking testbench for the Fitch parsimony node-cost engine.
`timescale 1ns / 1ps

module tb_fitch_parsimony_node_cost;
	import fpnc_pkg::*;

	localparam int NODES        = DEF_MAX_NODES;
	localparam int SITES        = DEF_MAX_SITES;
	// longest combine walks SITES sites, then reads and sums costs and registers the output
	localparam int DRAIN_CYCLES = SITES + 8;
	// watchdog bound on the length of the whole run
	localparam int CYCLE_LIMIT  = 2_000_000;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                busy;
	fpnc_req_t           request = '0;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [NSITES_W-1:0] cfg_data = '0;
	logic                result_valid;
	fpnc_res_t           result;

	fitch_parsimony_node_cost i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.request      (request),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.result       (result)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Shadow of the engine: per-node site sets and costs, plus which
	// entries hold a defined value. The stimulus only ever combines
	// children whose walked sites and cost are known, since the hardware
	// stores power up undefined.
	// ------------------------------------------------------------------
	logic [SET_W-1:0]  node_sets  [NODES][SITES];
	logic [COST_W-1:0] node_costs [NODES];
	bit                set_known  [NODES][SITES];
	bit                cost_known [NODES];
	int                sites_cfg = 1;       // num_sites as last written (reset value 1)

	fpnc_res_t expected_costs [$];          // costs still owed by the engine, oldest first
	fpnc_res_t oldest_cost;
	int        mismatch_count = 0;
	int        idle_pct = 0;                // sender idle chance per cycle, percent
	int        cycle_count = 0;

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $time, msg);
		mismatch_count++;
	endtask

	// Sites a combine actually walks for a given num_sites setting.
	function automatic int walk_len(input int cfg);
		return (cfg > SITES) ? SITES : cfg;
	endfunction

	// Update the shadow for one accepted request; a combine queues its cost.
	task automatic predict_node_cost(input fpnc_req_t r);
		int               n;
		int               s;
		int               changes;
		int unsigned      total;
		logic [SET_W-1:0] a;
		logic [SET_W-1:0] b;
		logic [SET_W-1:0] merged;
		fpnc_res_t        res;
		if (r.mode == MODE_LOAD) begin
			node_sets[r.node][r.site] = r.site_set;
			set_known[r.node][r.site] = 1'b1;
			node_costs[r.node]        = '0;
			cost_known[r.node]        = 1'b1;
		end else begin
			n       = walk_len(sites_cfg);
			changes = 0;
			// per site: both children read before the destination is written,
			// so a destination equal to a child behaves as in hardware
			for (s = 0; s < n; s++) begin
				a      = node_sets[r.left_child][s];
				b      = node_sets[r.right_child][s];
				merged = a & b;
				if (merged == '0) begin
					merged = a | b;
					changes++;
				end
				node_sets[r.node][s] = merged;
				set_known[r.node][s] = 1'b1;
			end
			total = node_costs[r.left_child] + node_costs[r.right_child] + changes;
			if (total > COST_MAX)
				total = COST_MAX;
			node_costs[r.node] = COST_W'(total);
			cost_known[r.node] = 1'b1;
			res.result_node = r.node;
			res.node_cost   = COST_W'(total);
			expected_costs.push_back(res);
		end
	endtask

	// Present one request and hold it until the engine takes it. start is left
	// high on return; the next call either replaces the request or idles.
	task automatic send_request(input fpnc_req_t r);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start   <= 1'b1;
		request <= r;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		predict_node_cost(r);
	endtask

	function automatic fpnc_req_t make_request(input logic mode, input int node,
			input int lc, input int rc, input int site, input int set_bits);
		fpnc_req_t r;
		r.mode        = mode;
		r.node        = NODE_FW'(node);
		r.left_child  = NODE_FW'(lc);
		r.right_child = NODE_FW'(rc);
		r.site        = SITE_FW'(site);
		r.site_set    = SET_W'(set_bits);
		return r;
	endfunction

	// Leaf load with random set; the child fields are don't-care and randomized.
	task automatic send_load(input int node, input int site);
		send_request(make_request(MODE_LOAD, node, $urandom_range(NODES - 1),
			$urandom_range(NODES - 1), site, $urandom_range(15)));
	endtask

	// Drop start, let all owed costs arrive, then cover trailing loads.
	task automatic wait_idle();
		start <= 1'b0;
		while (expected_costs.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// num_sites is only changed with the engine drained.
	task automatic write_num_sites(input int value);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data  <= NSITES_W'(value);
		do
			@(posedge clk);
		while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
		sites_cfg = value;
	endtask

	// A node may be a child when every walked site and its cost are defined.
	function automatic bit node_ready(input int k, input int n);
		int s;
		if (!cost_known[k])
			return 1'b0;
		for (s = 0; s < n; s++)
			if (!set_known[k][s])
				return 1'b0;
		return 1'b1;
	endfunction

	// Make sure at least one node can serve as a child at walk length n,
	// filling the node that is closest to complete.
	task automatic prime_ready_node(input int n);
		int k;
		int s;
		int miss;
		int best;
		int best_miss;
		best      = 0;
		best_miss = SITES + 1;
		for (k = 0; k < NODES; k++) begin
			if (node_ready(k, n))
				return;
			miss = 0;
			for (s = 0; s < n; s++)
				if (!set_known[k][s])
					miss++;
			if (miss < best_miss) begin
				best      = k;
				best_miss = miss;
			end
		end
		for (s = 0; s < n; s++)
			if (!set_known[best][s])
				send_load(best, s);
		if (!cost_known[best])
			send_load(best, 0);
	endtask

	// Mostly combines of well-defined children into any node, the rest leaf
	// loads that reshape sites inside the walk (sometimes anywhere).
	task automatic send_random_request(input int n);
		int        pool [$];
		int        k;
		fpnc_req_t r;
		for (k = 0; k < NODES; k++)
			if (node_ready(k, n))
				pool.push_back(k);
		r = make_request(MODE_LOAD, $urandom_range(NODES - 1), $urandom_range(NODES - 1),
			$urandom_range(NODES - 1), $urandom_range(255), $urandom_range(15));
		if (pool.size() != 0 && $urandom_range(99) < 60) begin
			r.mode        = MODE_COMBINE;
			r.left_child  = NODE_FW'(pool[$urandom_range(pool.size() - 1)]);
			r.right_child = NODE_FW'(pool[$urandom_range(pool.size() - 1)]);
			if ($urandom_range(99) < 15)
				r.node = r.left_child;    // in-place merge
		end else if (n != 0 && $urandom_range(99) < 75) begin
			r.site = SITE_FW'($urandom_range(n - 1));
		end
		send_request(r);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Reset value of num_sites (one site): loads at field extremes, then
	// combines covering intersection, disjoint union, two empty sets and
	// a destination that is also a child. Don't-care fields are nonzero in some requests.
	task automatic test_leaf_and_combine();
		idle_pct = 0;
		send_request(make_request(MODE_LOAD, 0, 31, 31, 0, 4'hF));
		send_request(make_request(MODE_LOAD, 31, 0, 0, 0, 4'h0));
		send_request(make_request(MODE_LOAD, 1, 5, 9, 255, 4'hA));
		send_request(make_request(MODE_LOAD, 1, 0, 0, 0, 4'b0101));
		send_request(make_request(MODE_LOAD, 2, 0, 0, 0, 4'b0011));
		send_request(make_request(MODE_COMBINE, 3, 0, 31, 255, 4'hF));  // disjoint
		send_request(make_request(MODE_COMBINE, 4, 1, 2, 0, 4'h0));     // overlap
		send_request(make_request(MODE_COMBINE, 1, 1, 2, 128, 4'h5));   // in place
		send_request(make_request(MODE_COMBINE, 31, 31, 31, 17, 4'h8)); // both empty
	endtask

	// num_sites = 0: no site walk, cost is just the child sum.
	task automatic test_zero_sites();
		write_num_sites(0);
		send_request(make_request(MODE_COMBINE, 5, 3, 31, 0, 4'h0));
		send_request(make_request(MODE_COMBINE, 5, 5, 0, 0, 4'h0));
	endtask

	// Self-combine of an empty leaf gives cost 2c+1 per step: reaches the
	// top of the range after 16 steps, then must stay there.
	task automatic test_cost_saturation();
		write_num_sites(1);
		send_request(make_request(MODE_LOAD, 6, 0, 0, 0, 4'h0));
		repeat (17)
			send_request(make_request(MODE_COMBINE, 6, 6, 6, 0, 4'h0));
	endtask

	task automatic run_walk_phase(input int cfg, input int pct, input int count);
		write_num_sites(cfg);
		idle_pct = pct;
		prime_ready_node(walk_len(cfg));
		repeat (count)
			send_random_request(walk_len(cfg));
	endtask

	// Settings include the empty walk, a full walk, the largest register
	// value (clamped to a full walk) and odd sizes. Results cannot be held
	// off, so only the sender idles; some phases run back to back.
	task automatic test_random_walks();
		run_walk_phase(3, 0, 38);
		run_walk_phase(256, 51, 38);
		run_walk_phase(0, 13, 38);
		run_walk_phase(511, 0, 38);
		run_walk_phase(1, 51, 38);
		run_walk_phase(12, 13, 38);
		run_walk_phase(200, 51, 38);
	endtask

	// ------------------------------------------------------------------
	// Result checking: every strobe must match the oldest owed cost.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n === 1'b1 && result_valid !== 1'b0) begin
			if (expected_costs.size() == 0) begin
				report_mismatch($sformatf("unexpected result node %0d cost %0d",
					result.result_node, result.node_cost));
			end else begin
				oldest_cost = expected_costs.pop_front();
				if (result.result_node !== oldest_cost.result_node)
					report_mismatch($sformatf("result_node %0d, want %0d",
						result.result_node, oldest_cost.result_node));
				if (result.node_cost !== oldest_cost.node_cost)
					report_mismatch($sformatf("node %0d cost %0d, want %0d",
						oldest_cost.result_node, result.node_cost,
						oldest_cost.node_cost));
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("fitch_parsimony_node_cost verification failed");
			$finish;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		test_leaf_and_combine();
		test_zero_sites();
		test_cost_saturation();
		test_random_walks();
		wait_idle();
		if (mismatch_count == 0)
			$display("fitch_parsimony_node_cost verification clean");
		else
			$display("fitch_parsimony_node_cost verification failed");
		$finish;
	end

endmodule
